// ===== hdl/crr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_pkg
// Shared types, operation codes, constants and helper functions for the
// centripetal Catmull-Rom resampler.
// ---------------------------------------------------------------------------
package crr_pkg;

	localparam int SAMPLES_MAX = 32;
	localparam int COORD_W     = 32;
	localparam int INTER_W     = COORD_W + 7;   // saturated intermediate, signed
	localparam int KNOT_W      = 21;            // interval in Q.20, up to 2^20
	localparam int EXP_W       = 23;            // scaled log2 exponent
	localparam int DEN_W       = 22;
	localparam int NUM_W       = 23;

	// Register indexes on the configuration port.
	localparam logic REG_SAMPLES = 1'b0;
	localparam logic REG_ALPHA   = 1'b1;

	// Datapath operations.
	localparam logic [4:0] OP_NOP      = 5'd0;
	localparam logic [4:0] OP_LOAD     = 5'd1;
	localparam logic [4:0] OP_KD       = 5'd2;
	localparam logic [4:0] OP_SQ       = 5'd3;
	localparam logic [4:0] OP_NORM     = 5'd4;
	localparam logic [4:0] OP_LOGI     = 5'd5;
	localparam logic [4:0] OP_LOG      = 5'd6;
	localparam logic [4:0] OP_EXP      = 5'd7;
	localparam logic [4:0] OP_MAX      = 5'd8;
	localparam logic [4:0] OP_IINIT    = 5'd9;
	localparam logic [4:0] OP_IMUL     = 5'd10;
	localparam logic [4:0] OP_ISTORE   = 5'd11;
	localparam logic [4:0] OP_DEG      = 5'd12;
	localparam logic [4:0] OP_TDIV     = 5'd13;
	localparam logic [4:0] OP_TSET     = 5'd14;
	localparam logic [4:0] OP_LMUL     = 5'd15;
	localparam logic [4:0] OP_LDIV     = 5'd16;
	localparam logic [4:0] OP_LEND     = 5'd17;
	localparam logic [4:0] OP_EMIT_P2  = 5'd18;
	localparam logic [4:0] OP_EMIT_IN  = 5'd19;
	localparam logic [4:0] OP_EMIT_P1  = 5'd20;
	localparam logic [4:0] OP_EMIT_RES = 5'd21;
	localparam logic [4:0] OP_SHIFT    = 5'd22;
	localparam logic [4:0] OP_CLEAR    = 5'd23;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] idx;
		logic [4:0] step;
		logic [2:0] lsel;
		logic [5:0] j;
		logic       last;
	} crr_cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_done;
		logic deg;
	} crr_status_t;

	typedef logic [15:0][31:0] ctab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rem;
		r   = 64'd0;
		b   = 64'h4000_0000_0000_0000;
		rem = v;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q.30 constants 2^(2^-i) for i = 1..16, each the root of the one before.
	function automatic ctab_t make_ctab();
		ctab_t       t;
		logic [63:0] c;
		c = 64'h8000_0000;
		for (int i = 0; i < 16; i++) begin
			c    = isqrt64(c << 30);
			t[i] = c[31:0];
		end
		return t;
	endfunction

	localparam ctab_t EXP2_TAB = make_ctab();

	function automatic logic [5:0] clamp_ns(input logic [5:0] s);
		return (s > 6'(SAMPLES_MAX)) ? 6'(SAMPLES_MAX) : s;
	endfunction

	function automatic logic signed [INTER_W-1:0] sat_inter(input logic signed [64:0] v);
		logic signed [64:0] hi;
		logic signed [64:0] lo;
		hi = (65'sd1 <<< (INTER_W - 1)) - 65'sd1;
		lo = -hi - 65'sd1;
		if (v > hi) return hi[INTER_W-1:0];
		if (v < lo) return lo[INTER_W-1:0];
		return v[INTER_W-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [INTER_W-1:0] v);
		logic signed [INTER_W-1:0] hi;
		logic signed [INTER_W-1:0] lo;
		hi = (INTER_W'(1) <<< (COORD_W - 1)) - INTER_W'(1);
		lo = -hi - INTER_W'(1);
		if (v > hi) return hi[COORD_W-1:0];
		if (v < lo) return lo[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

endpackage

// ===== hdl/crr_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module crr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [crr_pkg::DEN_W-1:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);

	logic [crr_pkg::DEN_W-1:0] rem_q;
	logic [crr_pkg::DEN_W-1:0] dsr_q;
	logic [63:0]               quo_q;
	logic [6:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [crr_pkg::DEN_W:0]   trial;

	assign trial = {rem_q, quo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= crr_pkg::DEN_W'(trial - {1'b0, dsr_q});
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[crr_pkg::DEN_W-1:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hdl/crr_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_datapath
// Point window, knot interval arithmetic, Barry-Goldman interpolation and
// the output register, driven one operation per cycle by the controller.
// ---------------------------------------------------------------------------
module crr_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crr_pkg::crr_cmd_t       cmd,
	output crr_pkg::crr_status_t    status,
	input  logic [5:0]              samples_per_segment,
	input  logic [8:0]              alpha,
	input  logic signed [31:0]      x,
	input  logic signed [31:0]      y,
	input  logic signed [31:0]      z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic                    degenerate,
	output logic                    last_of_run
);

	localparam int IW = crr_pkg::INTER_W;
	localparam int EW = crr_pkg::EXP_W;
	localparam int KW = crr_pkg::KNOT_W;
	localparam int NW = crr_pkg::NUM_W;
	localparam int DW = crr_pkg::DEN_W;

	logic signed [31:0] p0_q [3];
	logic signed [31:0] p1_q [3];
	logic signed [31:0] p2_q [3];
	logic signed [31:0] in_q [3];

	// Knot exponent working registers.
	logic [31:0]   d_q [3];
	logic          kshift_q;
	logic          zk_q;
	logic [63:0]   s_q;
	logic [5:0]    n_q;
	logic [31:0]   m_q;
	logic [15:0]   f_q;
	logic [EW-1:0] e_q [3];
	logic          z_q [3];
	logic [EW-1:0] emax_q;

	// Interval working registers.
	logic [15:0]   g_q;
	logic [30:0]   r_q;
	logic [7:0]    sh_q;
	logic [KW-1:0] u_q [3];
	logic          deg_q;

	// Interpolation registers.
	logic [DW-1:0]        t_q;
	logic signed [62:0]   prod_q;
	logic signed [IW-1:0] a_q;
	logic [DW-1:0]        den_q;
	logic                 neg_q;
	logic signed [IW-1:0] lv_q [5];
	logic signed [IW-1:0] res_q [3];

	// Output register.
	logic                 ovalid_q;
	logic signed [31:0]   ox_q;
	logic signed [31:0]   oy_q;
	logic signed [31:0]   oz_q;
	logic                 odeg_q;
	logic                 olast_q;

	logic                 div_start;
	logic [63:0]          div_dividend;
	logic [DW-1:0]        div_divisor;
	logic [63:0]          quo;
	logic                 div_done;

	logic [5:0]           ns;
	logic                 out_free;

	crr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quo),
		.done     (div_done)
	);

	assign ns       = crr_pkg::clamp_ns(samples_per_segment);
	assign out_free = !ovalid_q || out_ready;

	// Pair selection for the knot difference.
	logic signed [31:0] ka [3];
	logic signed [31:0] kb [3];
	logic [31:0]        dabs [3];
	logic [31:0]        dmax;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			case (cmd.idx)
				2'd0: begin
					ka[c] = p0_q[c];
					kb[c] = p1_q[c];
				end
				2'd1: begin
					ka[c] = p1_q[c];
					kb[c] = p2_q[c];
				end
				default: begin
					ka[c] = p2_q[c];
					kb[c] = in_q[c];
				end
			endcase
		end
	end

	always_comb begin
		logic signed [32:0] df;
		dmax = 32'd0;
		for (int c = 0; c < 3; c++) begin
			df      = 33'(kb[c]) - 33'(ka[c]);
			dabs[c] = df[32] ? 32'(-df) : df[31:0];
			if (dabs[c] > dmax) dmax = dabs[c];
		end
	end

	// One square of the sum per cycle.
	logic [31:0] dsel;
	logic [30:0] dk;
	logic [61:0] dsq;

	assign dsel = (cmd.idx == 2'd0) ? d_q[0] : (cmd.idx == 2'd1) ? d_q[1] : d_q[2];
	assign dk   = kshift_q ? dsel[31:1] : dsel[30:0];
	assign dsq  = 62'(dk) * 62'(dk);

	// Normalising shift, halving its width each cycle.
	logic [6:0] shamt;
	logic       top_zero;

	assign shamt    = 7'd32 >> cmd.step[2:0];
	assign top_zero = ((s_q >> (7'd64 - shamt)) == 64'd0);

	// Repeated squaring for the log2 fraction.
	logic [63:0] msq;
	logic [32:0] mm;

	assign msq = 64'(m_q) * 64'(m_q);
	assign mm  = msq[63:31];

	// Exponent scaled by alpha.
	logic [EW-1:0] lg;
	logic [31:0]   lgp;

	assign lg  = {1'b0, n_q, f_q} + (kshift_q ? EW'(32'h2_0000) : EW'(0));
	assign lgp = 32'(lg) * 32'(alpha);

	logic [EW-1:0] emax;
	always_comb begin
		emax = e_q[0];
		if (e_q[1] > emax) emax = e_q[1];
		if (e_q[2] > emax) emax = e_q[2];
	end

	logic [EW-1:0] nn;
	logic [EW-1:0] esel;
	logic          frnz;

	assign esel = (cmd.idx == 2'd0) ? e_q[0] : (cmd.idx == 2'd1) ? e_q[1] : e_q[2];
	assign nn   = emax_q - esel;
	assign frnz = (nn[15:0] != 16'd0);

	logic [3:0]  tix;
	logic [3:0]  bix;
	logic [62:0] rprod;

	assign tix   = 4'(cmd.step - 5'd1);
	assign bix   = 4'(5'd16 - cmd.step);
	assign rprod = 63'(r_q) * 63'(crr_pkg::EXP2_TAB[tix]);

	// Knot values and lerp operand selection.
	logic signed [NW-1:0] t1;
	logic signed [NW-1:0] t2;
	logic signed [NW-1:0] t3;
	logic signed [NW-1:0] tt;
	logic signed [IW-1:0] op_a;
	logic signed [IW-1:0] op_b;
	logic signed [NW-1:0] op_num;
	logic signed [NW-1:0] op_den;
	logic signed [IW-1:0] c0;
	logic signed [IW-1:0] c1;
	logic signed [IW-1:0] c2;
	logic signed [IW-1:0] c3;

	assign t1 = NW'(u_q[0]);
	assign t2 = t1 + NW'(u_q[1]);
	assign t3 = t2 + NW'(u_q[2]);
	assign tt = NW'(t_q);

	always_comb begin
		c0 = IW'(p0_q[0]);
		c1 = IW'(p1_q[0]);
		c2 = IW'(p2_q[0]);
		c3 = IW'(in_q[0]);
		case (cmd.idx)
			2'd1: begin
				c0 = IW'(p0_q[1]);
				c1 = IW'(p1_q[1]);
				c2 = IW'(p2_q[1]);
				c3 = IW'(in_q[1]);
			end
			2'd2: begin
				c0 = IW'(p0_q[2]);
				c1 = IW'(p1_q[2]);
				c2 = IW'(p2_q[2]);
				c3 = IW'(in_q[2]);
			end
			default: ;
		endcase
	end

	always_comb begin
		case (cmd.lsel)
			3'd0: begin
				op_a = c0; op_b = c1; op_num = tt;      op_den = t1;
			end
			3'd1: begin
				op_a = c1; op_b = c2; op_num = tt - t1; op_den = t2 - t1;
			end
			3'd2: begin
				op_a = c2; op_b = c3; op_num = tt - t2; op_den = t3 - t2;
			end
			3'd3: begin
				op_a = lv_q[0]; op_b = lv_q[1]; op_num = tt; op_den = t2;
			end
			3'd4: begin
				op_a = lv_q[1]; op_b = lv_q[2]; op_num = tt - t1; op_den = t3 - t1;
			end
			default: begin
				op_a = lv_q[3]; op_b = lv_q[4]; op_num = tt - t1; op_den = t2 - t1;
			end
		endcase
	end

	logic signed [IW:0]   ldiff;
	logic signed [62:0]   lprod;
	logic [62:0]          pmag;
	logic signed [64:0]   qs;
	logic signed [64:0]   lsum;
	logic signed [IW-1:0] lres;
	logic [26:0]          jprod;

	assign ldiff = (IW+1)'(op_b) - (IW+1)'(op_a);
	assign lprod = 63'(ldiff) * 63'(op_num);
	assign pmag  = prod_q[62] ? 63'(-prod_q) : 63'(prod_q);
	assign qs    = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign lsum  = 65'(a_q) + qs;
	assign lres  = crr_pkg::sat_inter(lsum);
	assign jprod = 27'(cmd.j) * 27'(u_q[1]);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = {1'b0, pmag};
		div_divisor  = den_q;
		if (cmd.op == crr_pkg::OP_TDIV) begin
			div_start    = 1'b1;
			div_dividend = 64'(jprod);
			div_divisor  = DW'(ns);
		end else if (cmd.op == crr_pkg::OP_LDIV) begin
			div_start = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			crr_pkg::OP_LOAD: begin
				in_q[0] <= x;
				in_q[1] <= y;
				in_q[2] <= z;
			end
			crr_pkg::OP_KD: begin
				for (int c = 0; c < 3; c++) d_q[c] <= dabs[c];
				kshift_q <= dmax[31];
				zk_q     <= (dmax == 32'd0);
				s_q      <= 64'd0;
				n_q      <= 6'd63;
			end
			crr_pkg::OP_SQ: s_q <= s_q + 64'(dsq);
			crr_pkg::OP_NORM: begin
				if (top_zero) begin
					s_q <= s_q << shamt;
					n_q <= n_q - shamt[5:0];
				end
			end
			crr_pkg::OP_LOGI: begin
				m_q <= s_q[63:32];
				f_q <= 16'd0;
			end
			crr_pkg::OP_LOG: begin
				f_q <= {f_q[14:0], mm[32]};
				m_q <= mm[32] ? mm[32:1] : mm[31:0];
			end
			crr_pkg::OP_EXP: begin
				// A zero-length chord contributes no exponent.
				e_q[cmd.idx] <= zk_q ? EW'(0) : lgp[31:9];
				z_q[cmd.idx] <= zk_q;
			end
			crr_pkg::OP_MAX: emax_q <= emax;
			crr_pkg::OP_IINIT: begin
				g_q  <= frnz ? 16'(17'h1_0000 - 17'(nn[15:0])) : 16'd0;
				r_q  <= 31'h4000_0000;
				sh_q <= 8'd10 + 8'(nn[EW-1:16]) + 8'(frnz);
			end
			crr_pkg::OP_IMUL: begin
				if (g_q[bix]) r_q <= rprod[60:30];
			end
			crr_pkg::OP_ISTORE: begin
				u_q[cmd.idx] <= (sh_q >= 8'd31) ? KW'(0) : KW'(r_q >> sh_q[4:0]);
			end
			crr_pkg::OP_DEG: begin
				deg_q <= ((alpha != 9'd0) && (z_q[0] || z_q[1] || z_q[2])) ||
					(u_q[0] == '0) || (u_q[1] == '0) || (u_q[2] == '0);
			end
			crr_pkg::OP_TSET: t_q <= DW'(u_q[0]) + quo[DW-1:0];
			crr_pkg::OP_LMUL: begin
				prod_q <= lprod;
				a_q    <= op_a;
				den_q  <= op_den[DW-1:0];
			end
			crr_pkg::OP_LDIV: neg_q <= prod_q[62];
			crr_pkg::OP_LEND: begin
				if (cmd.lsel == 3'd5) res_q[cmd.idx] <= lres;
				else lv_q[cmd.lsel] <= lres;
			end
			default: ;
		endcase
	end

	// The window is control-visible state, so it is cleared on reset and at
	// the end of a curve; everything above is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				p0_q[c] <= '0;
				p1_q[c] <= '0;
				p2_q[c] <= '0;
			end
		end else if (cmd.op == crr_pkg::OP_CLEAR) begin
			for (int c = 0; c < 3; c++) begin
				p0_q[c] <= '0;
				p1_q[c] <= '0;
				p2_q[c] <= '0;
			end
		end else if (cmd.op == crr_pkg::OP_SHIFT) begin
			for (int c = 0; c < 3; c++) begin
				p0_q[c] <= p1_q[c];
				p1_q[c] <= p2_q[c];
				p2_q[c] <= in_q[c];
			end
		end
	end

	logic is_emit;
	assign is_emit = (cmd.op == crr_pkg::OP_EMIT_P2) || (cmd.op == crr_pkg::OP_EMIT_IN) ||
		(cmd.op == crr_pkg::OP_EMIT_P1) || (cmd.op == crr_pkg::OP_EMIT_RES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (is_emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_emit) begin
			olast_q <= cmd.last;
			case (cmd.op)
				crr_pkg::OP_EMIT_P2: begin
					ox_q <= p2_q[0]; oy_q <= p2_q[1]; oz_q <= p2_q[2]; odeg_q <= 1'b0;
				end
				crr_pkg::OP_EMIT_IN: begin
					ox_q <= in_q[0]; oy_q <= in_q[1]; oz_q <= in_q[2]; odeg_q <= 1'b0;
				end
				crr_pkg::OP_EMIT_P1: begin
					ox_q <= p1_q[0]; oy_q <= p1_q[1]; oz_q <= p1_q[2]; odeg_q <= 1'b1;
				end
				default: begin
					ox_q   <= crr_pkg::sat_coord(res_q[0]);
					oy_q   <= crr_pkg::sat_coord(res_q[1]);
					oz_q   <= crr_pkg::sat_coord(res_q[2]);
					odeg_q <= 1'b0;
				end
			endcase
		end
	end

	assign status.out_free = out_free;
	assign status.div_done = div_done;
	assign status.deg      = deg_q;

	assign out_valid   = ovalid_q;
	assign out_x       = ox_q;
	assign out_y       = oy_q;
	assign out_z       = oz_q;
	assign degenerate  = odeg_q;
	assign last_of_run = olast_q;

endmodule

// ===== hdl/crr_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_ctrl
// Sequencer: decides which points a control point produces and steps the
// datapath through knot exponents, intervals and per-sample interpolation.
// ---------------------------------------------------------------------------
module crr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 end_of_curve,
	input  logic [5:0]           samples_per_segment,
	input  crr_pkg::crr_status_t status,
	output crr_pkg::crr_cmd_t    cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_PAIR0  = 5'd2;
	localparam logic [4:0] S_PAIR1  = 5'd3;
	localparam logic [4:0] S_KD     = 5'd4;
	localparam logic [4:0] S_SQ     = 5'd5;
	localparam logic [4:0] S_NORM   = 5'd6;
	localparam logic [4:0] S_LOGI   = 5'd7;
	localparam logic [4:0] S_LOG    = 5'd8;
	localparam logic [4:0] S_EXP    = 5'd9;
	localparam logic [4:0] S_MAX    = 5'd10;
	localparam logic [4:0] S_IINIT  = 5'd11;
	localparam logic [4:0] S_IMUL   = 5'd12;
	localparam logic [4:0] S_ISTORE = 5'd13;
	localparam logic [4:0] S_DEG    = 5'd14;
	localparam logic [4:0] S_SAMP   = 5'd15;
	localparam logic [4:0] S_TWAIT  = 5'd16;
	localparam logic [4:0] S_TSET   = 5'd17;
	localparam logic [4:0] S_LMUL   = 5'd18;
	localparam logic [4:0] S_LDIV   = 5'd19;
	localparam logic [4:0] S_LWAIT  = 5'd20;
	localparam logic [4:0] S_LEND   = 5'd21;
	localparam logic [4:0] S_SEMIT  = 5'd22;
	localparam logic [4:0] S_SEGEND = 5'd23;
	localparam logic [4:0] S_UPD    = 5'd24;

	logic [4:0] state_q, state_d;
	logic [1:0] seen_q, seen_d;
	logic [1:0] cnt_q, cnt_d;
	logic       end_q, end_d;
	logic       pend_q, pend_d;
	logic [1:0] k_q, k_d;
	logic [4:0] step_q, step_d;
	logic [2:0] l_q, l_d;
	logic [5:0] j_q, j_d;
	logic [5:0] ns;

	assign ns = crr_pkg::clamp_ns(samples_per_segment);

	always_comb begin
		state_d  = state_q;
		seen_d   = seen_q;
		cnt_d    = cnt_q;
		end_d    = end_q;
		pend_d   = pend_q;
		k_d      = k_q;
		step_d   = step_q;
		l_d      = l_q;
		j_d      = j_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.op   = crr_pkg::OP_NOP;
		cmd.idx  = k_q;
		cmd.step = step_q;
		cmd.lsel = l_q;
		cmd.j    = j_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = crr_pkg::OP_LOAD;
					end_d   = end_of_curve;
					cnt_d   = seen_q;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (cnt_q == 2'd1) begin
					pend_d  = 1'b0;
					state_d = S_PAIR0;
				end else if (cnt_q == 2'd3) begin
					k_d     = 2'd0;
					state_d = S_KD;
				end else if (end_q && cnt_q != 2'd0) begin
					pend_d  = 1'b1;
					state_d = S_PAIR0;
				end else begin
					state_d = S_UPD;
				end
			end
			S_PAIR0: begin
				if (status.out_free) begin
					cmd.op  = crr_pkg::OP_EMIT_P2;
					state_d = S_PAIR1;
				end
			end
			S_PAIR1: begin
				if (status.out_free) begin
					cmd.op   = crr_pkg::OP_EMIT_IN;
					cmd.last = pend_q || !end_q;
					if (!pend_q && end_q) begin
						pend_d  = 1'b1;
						state_d = S_PAIR0;
					end else begin
						state_d = S_UPD;
					end
				end
			end
			S_KD: begin
				cmd.op  = crr_pkg::OP_KD;
				step_d  = 5'd0;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op  = crr_pkg::OP_SQ;
				cmd.idx = step_q[1:0];
				if (step_q == 5'd2) begin
					step_d  = 5'd0;
					state_d = S_NORM;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			S_NORM: begin
				cmd.op = crr_pkg::OP_NORM;
				if (step_q == 5'd5) state_d = S_LOGI;
				else step_d = step_q + 5'd1;
			end
			S_LOGI: begin
				cmd.op  = crr_pkg::OP_LOGI;
				step_d  = 5'd0;
				state_d = S_LOG;
			end
			S_LOG: begin
				cmd.op = crr_pkg::OP_LOG;
				if (step_q == 5'd15) state_d = S_EXP;
				else step_d = step_q + 5'd1;
			end
			S_EXP: begin
				cmd.op = crr_pkg::OP_EXP;
				if (k_q == 2'd2) begin
					state_d = S_MAX;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = S_KD;
				end
			end
			S_MAX: begin
				cmd.op  = crr_pkg::OP_MAX;
				k_d     = 2'd0;
				state_d = S_IINIT;
			end
			S_IINIT: begin
				cmd.op  = crr_pkg::OP_IINIT;
				step_d  = 5'd1;
				state_d = S_IMUL;
			end
			S_IMUL: begin
				cmd.op = crr_pkg::OP_IMUL;
				if (step_q == 5'd16) state_d = S_ISTORE;
				else step_d = step_q + 5'd1;
			end
			S_ISTORE: begin
				cmd.op = crr_pkg::OP_ISTORE;
				if (k_q == 2'd2) begin
					state_d = S_DEG;
				end else begin
					k_d     = k_q + 2'd1;
					state_d = S_IINIT;
				end
			end
			S_DEG: begin
				cmd.op  = crr_pkg::OP_DEG;
				j_d     = 6'd0;
				state_d = S_SAMP;
			end
			S_SAMP: begin
				if (j_q == ns) begin
					state_d = S_SEGEND;
				end else if (status.deg) begin
					state_d = S_SEMIT;
				end else begin
					cmd.op  = crr_pkg::OP_TDIV;
					state_d = S_TWAIT;
				end
			end
			S_TWAIT: begin
				if (status.div_done) state_d = S_TSET;
			end
			S_TSET: begin
				cmd.op  = crr_pkg::OP_TSET;
				k_d     = 2'd0;
				l_d     = 3'd0;
				state_d = S_LMUL;
			end
			S_LMUL: begin
				// k holds the coordinate during interpolation.
				cmd.op  = crr_pkg::OP_LMUL;
				state_d = S_LDIV;
			end
			S_LDIV: begin
				cmd.op  = crr_pkg::OP_LDIV;
				state_d = S_LWAIT;
			end
			S_LWAIT: begin
				if (status.div_done) state_d = S_LEND;
			end
			S_LEND: begin
				cmd.op = crr_pkg::OP_LEND;
				if (l_q == 3'd5) begin
					l_d = 3'd0;
					if (k_q == 2'd2) begin
						state_d = S_SEMIT;
					end else begin
						k_d     = k_q + 2'd1;
						state_d = S_LMUL;
					end
				end else begin
					l_d     = l_q + 3'd1;
					state_d = S_LMUL;
				end
			end
			S_SEMIT: begin
				if (status.out_free) begin
					cmd.op   = status.deg ? crr_pkg::OP_EMIT_P1 : crr_pkg::OP_EMIT_RES;
					cmd.last = (j_q + 6'd1 == ns) && !end_q;
					j_d      = j_q + 6'd1;
					state_d  = S_SAMP;
				end
			end
			S_SEGEND: begin
				if (end_q) begin
					pend_d  = 1'b1;
					state_d = S_PAIR0;
				end else begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.op  = end_q ? crr_pkg::OP_CLEAR : crr_pkg::OP_SHIFT;
				seen_d  = end_q ? 2'd0 : ((cnt_q == 2'd3) ? 2'd3 : cnt_q + 2'd1);
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q  <= 2'd0;
			cnt_q   <= 2'd0;
			end_q   <= 1'b0;
			pend_q  <= 1'b0;
			k_q     <= 2'd0;
			step_q  <= 5'd0;
			l_q     <= 3'd0;
			j_q     <= 6'd0;
		end else begin
			state_q <= state_d;
			seen_q  <= seen_d;
			cnt_q   <= cnt_d;
			end_q   <= end_d;
			pend_q  <= pend_d;
			k_q     <= k_d;
			step_q  <= step_d;
			l_q     <= l_d;
			j_q     <= j_d;
		end
	end

endmodule

// ===== hdl/centripetal_catmull_rom_resampler.sv =====
`timescale 1ns / 1ps
// An input that only shifts the window passes through the dispatch and update states; a pair of
// points adds an emit state for each point. An interior segment first computes the three knot
// intervals, then per sample a time value plus 18 interpolations, all on one shared divider;
// only one control point is in flight at a time.
// Reset (asynchronous, active low) empties the window, zeroes the point count and
// restores 8 samples per segment and alpha 128.
// ---------------------------------------------------------------------------
// centripetal_catmull_rom_resampler
// Streaming centripetal Catmull-Rom resampler with an APB configuration port.
// ---------------------------------------------------------------------------
module centripetal_catmull_rom_resampler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  logic signed [31:0] z,
	input  logic               end_of_curve,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               degenerate,
	output logic               last_of_run,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [5:0] samples_q;
	logic [8:0] alpha_q;
	logic       wr_en;

	crr_pkg::crr_cmd_t    cmd;
	crr_pkg::crr_status_t status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= 6'd8;
			alpha_q   <= 9'd128;
		end else if (wr_en) begin
			case (paddr[2])
				crr_pkg::REG_SAMPLES: samples_q <= pwdata[5:0];
				crr_pkg::REG_ALPHA:   alpha_q   <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			crr_pkg::REG_SAMPLES: prdata = 32'(samples_q);
			crr_pkg::REG_ALPHA:   prdata = 32'(alpha_q);
			default:              prdata = 32'd0;
		endcase
	end

	crr_ctrl u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.end_of_curve        (end_of_curve),
		.samples_per_segment (samples_q),
		.status              (status),
		.cmd                 (cmd)
	);

	crr_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.samples_per_segment (samples_q),
		.alpha               (alpha_q),
		.x                   (x),
		.y                   (y),
		.z                   (z),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.out_x               (out_x),
		.out_y               (out_y),
		.out_z               (out_z),
		.degenerate          (degenerate),
		.last_of_run         (last_of_run)
	);

endmodule

// ===== hdl/crr_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crr_checker
// Port-level checks for the resampler, bound to the top level.
// ---------------------------------------------------------------------------
module crr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z,
	input logic               degenerate,
	input logic               last_of_run
);

	// Only one control point is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// When the block is ready again, any result still held is the last of its run.
	a_idle_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last_of_run)
		else $error("ready for input while a run is unfinished");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
		$stable(out_z) && $stable(degenerate) && $stable(last_of_run))
		else $error("stalled output transaction changed");

endmodule

bind centripetal_catmull_rom_resampler crr_checker u_crr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_x       (out_x),
	.out_y       (out_y),
	.out_z       (out_z),
	.degenerate  (degenerate),
	.last_of_run (last_of_run)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the Catmull-Rom resampler. The testbench sends
// polylines of control points, keeps its own fixed-point model of the spline
// arithmetic and checks every output point in order. It steps through several
// sample counts and exponents, including the extremes.
// ---------------------------------------------------------------------------
module tb;

	localparam logic [2:0] ADDR_SAMPLES = {crr_pkg::REG_SAMPLES, 2'b00};
	localparam logic [2:0] ADDR_ALPHA   = {crr_pkg::REG_ALPHA, 2'b00};
	localparam int         KNOT_Q       = 20;
	localparam longint     LERP_LIM     = (64'sd1 <<< 38) - 1;
	localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] CMIN = 32'sh8000_0000;

	typedef longint pt_t [3];
	typedef enum logic [1:0] {ROW_MODEL, ROW_SILENT, ROW_PAIR} row_kind_t;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic               deg;
		logic               last;
	} curve_pt_t;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic               eoc;
		row_kind_t          kind;
	} ctrl_row_t;

	logic               clk, arst_n;
	logic               in_valid, in_ready;
	logic signed [31:0] x, y, z;
	logic               end_of_curve;
	logic               out_valid, out_ready;
	logic signed [31:0] out_x, out_y, out_z;
	logic               degenerate, last_of_run;
	logic               psel, penable, pwrite, pready;
	logic [2:0]         paddr;
	logic [31:0]        pwdata, prdata;

	centripetal_catmull_rom_resampler i_dut (.*);

	// Predictor state
	pt_t         win [3];
	int unsigned held_pts;
	logic [5:0]  samples_cfg;
	logic [8:0]  alpha_cfg;

	curve_pt_t   pending_pts [$];
	int          errors, checked, deg_seen, points_sent;
	logic signed [31:0] last_x, last_y, last_z;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#250ms;
		$display("Timeout with %0d points still expected", pending_pts.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int bit_len(longint unsigned v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned log2_q16(longint unsigned s);
		int              n;
		longint unsigned m, f;
		n = bit_len(s) - 1;
		m = (n >= 31) ? (s >> (n - 31)) : (s << (31 - n));
		f = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			f <<= 1;
			if (m >= (64'd1 << 32)) begin
				m >>= 1;
				f |= 1;
			end
		end
		return (longint'(n) << 16) | f;
	endfunction

	// Scaled log2 of the squared distance between two points
	function automatic longint unsigned knot_exponent(pt_t a, pt_t b, output bit coincide);
		longint unsigned d [3];
		longint unsigned mx, s;
		longint          t;
		int              k;
		mx = 0;
		s  = 0;
		for (int i = 0; i < 3; i++) begin
			t    = b[i] - a[i];
			d[i] = (t < 0) ? -t : t;
			if (d[i] > mx) mx = d[i];
		end
		coincide = (mx == 0);
		if (mx == 0) return 0;
		k = (bit_len(mx) > 31) ? bit_len(mx) - 31 : 0;
		for (int i = 0; i < 3; i++) s += (d[i] >> k) * (d[i] >> k);
		return ((log2_q16(s) + (longint'(2 * k) << 16)) * alpha_cfg) >> 9;
	endfunction

	// 2^-n with n in Q.16, returned in Q.20
	function automatic longint unsigned knot_interval(longint unsigned n);
		longint unsigned fr, g, r, c;
		longint          sh;
		fr = n & 64'hFFFF;
		g  = (fr != 0) ? 65536 - fr : 0;
		r  = 64'd1 << 30;
		c  = 64'd1 << 31;
		sh = KNOT_Q - 30 - longint'(n >> 16) - ((fr != 0) ? 1 : 0);
		for (int i = 1; i <= 16; i++) begin
			c = int_sqrt(c << 30);
			if (((g >> (16 - i)) & 1) != 0) r = (r * c) >> 30;
		end
		if (sh >= 0) return r << sh;
		if (-sh >= 63) return 0;
		return r >> (-sh);
	endfunction

	function automatic longint blend(longint a, longint b, longint num, longint den);
		longint v;
		v = a + ((b - a) * num) / den;
		if (v > LERP_LIM) return LERP_LIM;
		if (v < -LERP_LIM - 1) return -LERP_LIM - 1;
		return v;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > longint'(CMAX)) return CMAX;
		if (v < longint'(CMIN)) return CMIN;
		return v[31:0];
	endfunction

	function automatic curve_pt_t make_pt(pt_t p, logic deg);
		curve_pt_t o;
		o.px   = clip32(p[0]);
		o.py   = clip32(p[1]);
		o.pz   = clip32(p[2]);
		o.deg  = deg;
		o.last = 1'b0;
		return o;
	endfunction

	// Barry-Goldman samples of the segment between the two newest window points
	function automatic void resample_segment(pt_t p3, inout curve_pt_t res [$]);
		int unsigned     ns;
		bit              z0, z1, z2, deg;
		longint unsigned e0, e1, e2, mx, u01, u12, u23;
		longint          t1, t2, t3, t, a1, a2, a3, b1, b2;
		pt_t             r;
		ns  = (samples_cfg > crr_pkg::SAMPLES_MAX) ? crr_pkg::SAMPLES_MAX : samples_cfg;
		e0  = knot_exponent(win[0], win[1], z0);
		e1  = knot_exponent(win[1], win[2], z1);
		e2  = knot_exponent(win[2], p3, z2);
		mx  = e0;
		if (e1 > mx) mx = e1;
		if (e2 > mx) mx = e2;
		u01 = knot_interval(mx - e0);
		u12 = knot_interval(mx - e1);
		u23 = knot_interval(mx - e2);
		deg = (alpha_cfg != 0 && (z0 || z1 || z2)) || u01 == 0 || u12 == 0 || u23 == 0;
		for (int unsigned j = 0; j < ns; j++) begin
			if (deg) begin
				res.push_back(make_pt(win[1], 1'b1));
				continue;
			end
			t1 = u01;
			t2 = t1 + longint'(u12);
			t3 = t2 + longint'(u23);
			t  = t1 + longint'((longint'(j) * u12) / ns);
			for (int c = 0; c < 3; c++) begin
				a1   = blend(win[0][c], win[1][c], t, t1);
				a2   = blend(win[1][c], win[2][c], t - t1, t2 - t1);
				a3   = blend(win[2][c], p3[c], t - t2, t3 - t2);
				b1   = blend(a1, a2, t, t2);
				b2   = blend(a2, a3, t - t1, t3 - t1);
				r[c] = blend(b1, b2, t - t1, t2 - t1);
			end
			res.push_back(make_pt(r, 1'b0));
		end
	endfunction

	function automatic void predict_points(logic signed [31:0] px, py, pz, logic eoc,
		output curve_pt_t res [$]);
		pt_t p;
		res  = {};
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		if (held_pts == 1) begin
			res.push_back(make_pt(win[2], 1'b0));
			res.push_back(make_pt(p, 1'b0));
		end
		if (held_pts == 3) resample_segment(p, res);
		if (eoc && held_pts >= 1) begin
			res.push_back(make_pt(win[2], 1'b0));
			res.push_back(make_pt(p, 1'b0));
		end
		if (res.size() > 0) res[res.size() - 1].last = 1'b1;
		if (eoc) begin
			for (int i = 0; i < 3; i++) win[i] = '{0, 0, 0};
			held_pts = 0;
		end else begin
			win[0]   = win[1];
			win[1]   = win[2];
			win[2]   = p;
			held_pts = (held_pts < 3) ? held_pts + 1 : 3;
		end
	endfunction

	// Sender side: a gap, then one control point held until it is taken
	task automatic send_point(logic signed [31:0] px, py, pz, logic eoc, row_kind_t kind);
		int        gap;
		curve_pt_t res [$];
		curve_pt_t prev_pt;
		curve_pt_t cur_pt;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		x            <= px;
		y            <= py;
		z            <= pz;
		end_of_curve <= eoc;
		do @(posedge clk); while (!in_ready);
		prev_pt.px = last_x;
		prev_pt.py = last_y;
		prev_pt.pz = last_z;
		predict_points(px, py, pz, eoc, res);
		// Rows that read straight off the table replace the model's answer
		if (kind == ROW_SILENT) begin
			res = {};
		end else if (kind == ROW_PAIR) begin
			prev_pt.deg  = 1'b0;
			prev_pt.last = 1'b0;
			cur_pt.px    = px;
			cur_pt.py    = py;
			cur_pt.pz    = pz;
			cur_pt.deg   = 1'b0;
			cur_pt.last  = 1'b1;
			res = {prev_pt, cur_pt};
		end
		foreach (res[i]) pending_pts.push_back(res[i]);
		last_x = px;
		last_y = py;
		last_z = pz;
		points_sent++;
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_SAMPLES) samples_cfg = data[5:0];
		else alpha_cfg = data[8:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Waits for every expected point, then lets a point that emits nothing settle
	task automatic drain_points();
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_coord(logic signed [31:0] prev);
		case ($urandom_range(0, 9))
			0: return prev;
			1: return ($urandom_range(0, 2) == 0) ? CMAX : ($urandom_range(0, 1) ? CMIN : 0);
			2: return prev + $signed($urandom_range(0, 6)) - 3;
			3: return $urandom;
			default: return prev + $signed($urandom_range(0, 2 << 20)) - (1 << 20);
		endcase
	endfunction

	// Random polylines; a repeated point gives a coincident pair
	task automatic send_curves(int count);
		int                 left;
		logic signed [31:0] nx, ny, nz;
		left = 0;
		for (int i = 0; i < count; i++) begin
			if (left == 0) left = $urandom_range(1, 7);
			if ($urandom_range(0, 7) == 0) begin
				nx = last_x;
				ny = last_y;
				nz = last_z;
			end else begin
				nx = pick_coord(last_x);
				ny = pick_coord(last_y);
				nz = pick_coord(last_z);
			end
			left--;
			// Close any curve still open on the last point of a phase
			send_point(nx, ny, nz, (left == 0 || i == count - 1), ROW_MODEL);
			if (i == count - 1) left = 0;
		end
	endtask

	// Receiver side with its own stalls and one long hold-off
	initial begin : receiver
		int        stall, quiet;
		bit        held_off;
		curve_pt_t want;
		stall    = 0;
		quiet    = 0;
		held_off = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_pts.size() == 0) begin
					errors++;
					if (errors <= 10) $display("Unexpected output point %0d %0d %0d",
						out_x, out_y, out_z);
				end else begin
					want = pending_pts.pop_front();
					if ({out_x, out_y, out_z, degenerate, last_of_run} !==
						{want.px, want.py, want.pz, want.deg, want.last}) begin
						errors++;
						if (errors <= 10) $display(
							"Point %0d: expected %0d %0d %0d deg %b last %b, got %0d %0d %0d deg %b last %b",
							checked, want.px, want.py, want.pz, want.deg, want.last,
							out_x, out_y, out_z, degenerate, last_of_run);
					end
					if (degenerate) deg_seen++;
				end
				checked++;
			end
			@(negedge clk);
			if (!held_off && checked >= 30) begin
				held_off = 1'b1;
				stall    = 600;
			end
			if (quiet > 0) quiet--;
			else if ($urandom_range(0, 199) == 0) quiet = 300;
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (quiet == 0 && $urandom_range(0, 9) < 3) begin
				stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	ctrl_row_t directed [] = '{
		'{32'sd0, 32'sd0, 32'sd0, 1'b1, ROW_SILENT},
		'{32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 1'b0, ROW_SILENT},
		'{32'sh5_0000, -32'sh1_0000, 32'sd0, 1'b0, ROW_PAIR},
		'{32'sha_0000, 32'sh4_0000, 32'sh2_0000, 1'b0, ROW_MODEL},
		'{32'shc_0000, 32'sh9_0000, -32'sh3_0000, 1'b0, ROW_MODEL},
		'{32'sh14_0000, 32'sh9_0000, 32'sd0, 1'b0, ROW_MODEL},
		'{32'sh14_0000, 32'sh9_0000, 32'sd0, 1'b0, ROW_MODEL},
		'{32'sh19_0000, 32'sh1_8000, 32'sh7_0000, 1'b1, ROW_MODEL},
		'{CMAX, CMAX, CMAX, 1'b0, ROW_SILENT},
		'{CMIN, CMIN, CMIN, 1'b0, ROW_PAIR},
		'{CMAX, CMIN, CMAX, 1'b0, ROW_MODEL},
		'{CMIN, CMAX, CMIN, 1'b0, ROW_MODEL},
		'{CMAX, CMAX, CMIN, 1'b0, ROW_MODEL},
		'{32'sd0, 32'sd0, 32'sd0, 1'b1, ROW_MODEL},
		'{-32'sd1, -32'sd1, -32'sd1, 1'b0, ROW_SILENT},
		'{32'sd1, 32'sd1, 32'sd1, 1'b1, ROW_MODEL},
		'{32'sd3, 32'sd0, 32'sd0, 1'b0, ROW_SILENT},
		'{32'sd0, 32'sd3, 32'sd0, 1'b0, ROW_PAIR},
		'{32'sd0, 32'sd0, 32'sd3, 1'b1, ROW_MODEL}
	};

	// Sample count, exponent and number of points for each random phase
	int phase_cfg [8][3] = '{
		'{2, 128, 16}, '{0, 0, 10}, '{63, 256, 6}, '{1, 511, 16},
		'{4, 0, 12}, '{3, 64, 12}, '{32, 200, 8}, '{5, 128, 11}
	};

	initial begin
		in_valid     = 1'b0;
		x            = '0;
		y            = '0;
		z            = '0;
		end_of_curve = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		errors       = 0;
		checked      = 0;
		deg_seen     = 0;
		points_sent  = 0;
		last_x       = 0;
		last_y       = 0;
		last_z       = 0;
		held_pts     = 0;
		samples_cfg  = 6'd8;
		alpha_cfg    = 9'd128;
		for (int i = 0; i < 3; i++) win[i] = '{0, 0, 0};
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].eoc,
				directed[i].kind);

		foreach (phase_cfg[p]) begin
			@(negedge clk);
			in_valid <= 1'b0;
			drain_points();
			write_reg(ADDR_SAMPLES, phase_cfg[p][0]);
			write_reg(ADDR_ALPHA, phase_cfg[p][1]);
			send_curves(phase_cfg[p][2]);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		drain_points();

		$display("Sent %0d control points over %0d register settings.", points_sent,
			$size(phase_cfg) + 1);
		$display("Checked %0d output points, %0d of them degenerate; %0d mismatches.",
			checked, deg_seen, errors);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/crr_pkg.sv
hdl/crr_div.sv
hdl/crr_datapath.sv
hdl/crr_ctrl.sv
hdl/centripetal_catmull_rom_resampler.sv
hdl/crr_checker.sv
test/tb.sv
